// ===== rtl/iwa_pkg.sv =====
// ----------------------------------------------------------------------------
// iwa_pkg: shared types and fp32 helpers for the instance world box unit
// Binary32 multiply and add split into a front half (mantissa product or
// aligned sum) and a back half (normalize and round to nearest even).
// ----------------------------------------------------------------------------
`default_nettype none

package iwa_pkg;

  typedef logic [31:0] f32_t;

  typedef enum logic [1:0] {
    KIND_FIN,
    KIND_INF,
    KIND_NAN
  } fp_kind_t;

  typedef struct packed {
    logic              s;
    fp_kind_t          kind;
    logic signed [11:0] e;
    logic [47:0]       p;
  } mul_mid_t;

  typedef struct packed {
    logic              s;
    fp_kind_t          kind;
    logic signed [11:0] e;
    logic [48:0]       sum;
  } add_mid_t;

  localparam int unsigned PIPE_DEPTH = 12;

  localparam f32_t FP_POS_BIG = 32'h7149F2CA;  // 1.0e30
  localparam f32_t FP_NEG_BIG = 32'hF149F2CA;  // -1.0e30
  localparam f32_t FP_QNAN    = 32'h7FC00000;

  function automatic logic fp_is_nan(input f32_t a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input f32_t a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  // Ordered integer key; both zeros map to the same key.
  function automatic logic [31:0] fp_key(input f32_t a);
    logic [31:0] x;
    x = (a[30:0] == 31'd0) ? 32'd0 : a;
    return x[31] ? ~x : {1'b1, x[30:0]};
  endfunction

  // Earlier operand a is kept unless b is strictly smaller; NaN never wins.
  function automatic f32_t pick_lo(input f32_t a, input f32_t b);
    f32_t r;
    if (fp_is_nan(b)) r = a;
    else if (fp_is_nan(a)) r = b;
    else if (fp_key(b) < fp_key(a)) r = b;
    else r = a;
    return r;
  endfunction

  function automatic f32_t pick_hi(input f32_t a, input f32_t b);
    f32_t r;
    if (fp_is_nan(b)) r = a;
    else if (fp_is_nan(a)) r = b;
    else if (fp_key(b) > fp_key(a)) r = b;
    else r = a;
    return r;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  // m has its leading one at bit 47; e is the biased exponent of 1.m.
  function automatic f32_t fp_round(input logic s, input logic signed [11:0] e,
                                    input logic [47:0] m);
    logic [47:0] m2;
    logic [11:0] sh;
    logic [5:0]  shv;
    logic [7:0]  ee;
    logic        g;
    logic        st;
    logic        inc;
    logic [30:0] res;
    f32_t        r;
    m2 = m;
    ee = e[7:0];
    sh = 12'd0;
    shv = 6'd0;
    if (e >= 12'sd255) begin
      r = {s, 8'hFF, 23'd0};
    end else begin
      if (e <= 12'sd0) begin
        // Subnormal result: denormalize with sticky before rounding.
        sh = 12'd1 - e;
        ee = 8'd0;
        if (sh >= 12'd48) begin
          m2 = {47'd0, |m};
        end else begin
          shv = sh[5:0];
          m2 = (m >> shv) | {47'd0, |(m & ((48'h1 << shv) - 48'h1))};
        end
      end
      g = m2[23];
      st = |m2[22:0];
      inc = g & (st | m2[24]);
      res = {ee, m2[46:24]} + {30'd0, inc};
      r = {s, res};
    end
    return r;
  endfunction

  function automatic mul_mid_t mul_front(input f32_t a, input f32_t b);
    mul_mid_t          r;
    logic [23:0]       ma;
    logic [23:0]       mb;
    logic signed [11:0] ea;
    logic signed [11:0] eb;
    logic              az;
    logic              bz;
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    ea = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
    eb = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    r.s = a[31] ^ b[31];
    r.e = ea + eb - 12'sd127;
    r.p = {24'd0, ma} * {24'd0, mb};
    if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && bz) || (fp_is_inf(b) && az))
      r.kind = KIND_NAN;
    else if (fp_is_inf(a) || fp_is_inf(b))
      r.kind = KIND_INF;
    else
      r.kind = KIND_FIN;
    return r;
  endfunction

  function automatic f32_t mul_back(input mul_mid_t x);
    logic [5:0] lz;
    f32_t       r;
    lz = lzc48(x.p);
    case (x.kind)
      KIND_NAN: r = FP_QNAN;
      KIND_INF: r = {x.s, 8'hFF, 23'd0};
      default: begin
        if (x.p == 48'd0) r = {x.s, 31'd0};
        else r = fp_round(x.s, x.e + 12'sd1 - $signed({6'd0, lz}), x.p << lz);
      end
    endcase
    return r;
  endfunction

  function automatic add_mid_t add_front(input f32_t a, input f32_t b);
    add_mid_t    r;
    f32_t        x;
    f32_t        y;
    logic [8:0]  ex;
    logic [8:0]  ey;
    logic [8:0]  d;
    logic [48:0] xa;
    logic [48:0] ya;
    logic [48:0] ysh;
    logic        st;
    logic        sub;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == 8'd0) ? 9'd1 : {1'b0, x[30:23]};
    ey = (y[30:23] == 8'd0) ? 9'd1 : {1'b0, y[30:23]};
    d = ex - ey;
    xa = {1'b0, |x[30:23], x[22:0], 24'd0};
    ya = {1'b0, |y[30:23], y[22:0], 24'd0};
    if (d >= 9'd49) begin
      ysh = 49'd0;
      st = |ya;
    end else begin
      ysh = ya >> d[5:0];
      st = |(ya & ((49'h1 << d[5:0]) - 49'h1));
    end
    ysh[0] = ysh[0] | st;
    sub = x[31] ^ y[31];
    r.sum = sub ? (xa - ysh) : (xa + ysh);
    r.e = $signed({3'd0, ex});
    r.s = x[31];
    if (r.sum == 49'd0) r.s = sub ? 1'b0 : x[31];
    if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && fp_is_inf(b) && sub))
      r.kind = KIND_NAN;
    else if (fp_is_inf(a) || fp_is_inf(b))
      r.kind = KIND_INF;
    else
      r.kind = KIND_FIN;
    return r;
  endfunction

  function automatic f32_t add_back(input add_mid_t x);
    logic [5:0] lz;
    f32_t       r;
    lz = lzc48(x.sum[47:0]);
    case (x.kind)
      KIND_NAN: r = FP_QNAN;
      KIND_INF: r = {x.s, 8'hFF, 23'd0};
      default: begin
        if (x.sum == 49'd0)
          r = {x.s, 31'd0};
        else if (x.sum[48])
          r = fp_round(x.s, x.e + 12'sd1, x.sum[48:1] | {47'd0, x.sum[0]});
        else
          r = fp_round(x.s, x.e - $signed({6'd0, lz}), x.sum[47:0] << lz);
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/instance_world_aabb_unit.sv =====
// ----------------------------------------------------------------------------
// instance_world_aabb_unit: world-space bounding box of a scene instance
// Maps the eight corners of an object box through a 3x4 affine matrix in
// fp32 and returns the per-axis minimum and maximum, with the index attached.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | instance index, box corners, matrix rows; tuser = valid flag
//  out_    | master    | world box low/high xyz and instance index
//
//  One request is taken every cycle unless a stall on out_tready holds the pipeline.
//  Stages: multiply, round, three add/round pairs, three min/max tree levels,
//  and the output register.
//  Reset clears only the stage valid bits.
//  A stall on out_tready holds every stage; nothing is dropped or repeated.
`default_nettype none

module instance_world_aabb_unit import iwa_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [31:0] instance_index, [95:32] box_lo_xy, [127:96] box_lo_z,
  // [191:128] box_hi_xy, [223:192] box_hi_z, [287:224] row0_xy,
  // [351:288] row0_zw, [415:352] row1_xy, [479:416] row1_zw,
  // [543:480] row2_xy, [607:544] row2_zw
  input  wire logic [607:0] in_tdata,
  // [0] source_valid
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] world_lo_x, [63:32] world_lo_y, [95:64] world_lo_z,
  // [127:96] world_hi_x, [159:128] world_hi_y, [191:160] world_hi_z,
  // [223:192] index_out
  output logic [223:0]      out_tdata
);

  logic                  en;
  logic [PIPE_DEPTH-1:0] v_r;
  logic [31:0]           idx_r [PIPE_DEPTH];
  logic                  src_r [PIPE_DEPTH];

  f32_t     mat [3][4];
  f32_t     bl [3];
  f32_t     bh [3];

  mul_mid_t mm_r [3][6];
  f32_t     m3a_r [3];
  f32_t     pr_r [3][6];
  f32_t     m3b_r [3];
  add_mid_t am1_r [3][4];
  f32_t     pzc_r [3][2];
  f32_t     m3c_r [3];
  f32_t     s1_r [3][4];
  f32_t     pzd_r [3][2];
  f32_t     m3d_r [3];
  add_mid_t am2_r [3][8];
  f32_t     m3e_r [3];
  f32_t     s2_r [3][8];
  f32_t     m3f_r [3];
  add_mid_t am3_r [3][8];
  f32_t     w_r [3][8];
  f32_t     lo9_r [3][4];
  f32_t     hi9_r [3][4];
  f32_t     lo10_r [3][2];
  f32_t     hi10_r [3][2];
  f32_t     lo11_r [3];
  f32_t     hi11_r [3];
  f32_t     lo_r [3];
  f32_t     hi_r [3];

  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = v_r[PIPE_DEPTH-1];
  assign out_tdata  = {idx_r[PIPE_DEPTH-1], hi_r[2], hi_r[1], hi_r[0],
                       lo_r[2], lo_r[1], lo_r[0]};

  always_comb begin
    bl[0] = in_tdata[63:32];
    bl[1] = in_tdata[95:64];
    bl[2] = in_tdata[127:96];
    bh[0] = in_tdata[159:128];
    bh[1] = in_tdata[191:160];
    bh[2] = in_tdata[223:192];
    for (int k = 0; k < 3; k++) begin
      mat[k][0] = in_tdata[224 + 128*k +: 32];
      mat[k][1] = in_tdata[256 + 128*k +: 32];
      mat[k][2] = in_tdata[288 + 128*k +: 32];
      mat[k][3] = in_tdata[320 + 128*k +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r[0] <= in_tdata[31:0];
      src_r[0] <= in_tuser;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        idx_r[i] <= idx_r[i-1];
        src_r[i] <= src_r[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        // Products: m0*x, m1*y, m2*z for the low and high box coordinate.
        mm_r[k][0] <= mul_front(mat[k][0], bl[0]);
        mm_r[k][1] <= mul_front(mat[k][0], bh[0]);
        mm_r[k][2] <= mul_front(mat[k][1], bl[1]);
        mm_r[k][3] <= mul_front(mat[k][1], bh[1]);
        mm_r[k][4] <= mul_front(mat[k][2], bl[2]);
        mm_r[k][5] <= mul_front(mat[k][2], bh[2]);
        m3a_r[k] <= mat[k][3];

        for (int j = 0; j < 6; j++) pr_r[k][j] <= mul_back(mm_r[k][j]);
        m3b_r[k] <= m3a_r[k];

        // Corner c picks x by bit 0, y by bit 1, z by bit 2.
        for (int j = 0; j < 4; j++) am1_r[k][j] <= add_front(pr_r[k][j & 1], pr_r[k][2 + (j >> 1)]);
        pzc_r[k][0] <= pr_r[k][4];
        pzc_r[k][1] <= pr_r[k][5];
        m3c_r[k] <= m3b_r[k];

        for (int j = 0; j < 4; j++) s1_r[k][j] <= add_back(am1_r[k][j]);
        pzd_r[k] <= pzc_r[k];
        m3d_r[k] <= m3c_r[k];

        for (int c = 0; c < 8; c++) am2_r[k][c] <= add_front(s1_r[k][c & 3], pzd_r[k][c >> 2]);
        m3e_r[k] <= m3d_r[k];

        for (int c = 0; c < 8; c++) s2_r[k][c] <= add_back(am2_r[k][c]);
        m3f_r[k] <= m3e_r[k];

        for (int c = 0; c < 8; c++) am3_r[k][c] <= add_front(s2_r[k][c], m3f_r[k]);

        for (int c = 0; c < 8; c++) w_r[k][c] <= add_back(am3_r[k][c]);

        // Tree keeps the earlier corner on ties, same as a fold in corner order.
        for (int j = 0; j < 4; j++) begin
          lo9_r[k][j] <= pick_lo(w_r[k][2*j], w_r[k][2*j+1]);
          hi9_r[k][j] <= pick_hi(w_r[k][2*j], w_r[k][2*j+1]);
        end
        for (int j = 0; j < 2; j++) begin
          lo10_r[k][j] <= pick_lo(lo9_r[k][2*j], lo9_r[k][2*j+1]);
          hi10_r[k][j] <= pick_hi(hi9_r[k][2*j], hi9_r[k][2*j+1]);
        end
        lo11_r[k] <= pick_lo(lo10_r[k][0], lo10_r[k][1]);
        hi11_r[k] <= pick_hi(hi10_r[k][0], hi10_r[k][1]);

        lo_r[k] <= src_r[PIPE_DEPTH-2] ? pick_lo(FP_POS_BIG, lo11_r[k]) : FP_POS_BIG;
        hi_r[k] <= src_r[PIPE_DEPTH-2] ? pick_hi(FP_NEG_BIG, hi11_r[k]) : FP_NEG_BIG;
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline moved during a stall");

  a_take_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && en |=> v_r[0])
    else $error("accepted request not in first stage");

  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !src_r[PIPE_DEPTH-1] |->
      lo_r[0] == FP_POS_BIG && lo_r[1] == FP_POS_BIG && lo_r[2] == FP_POS_BIG &&
      hi_r[0] == FP_NEG_BIG && hi_r[1] == FP_NEG_BIG && hi_r[2] == FP_NEG_BIG)
    else $error("invalid source did not give the identity box");

endmodule

`default_nettype wire
